[sv/sca_pkg.sv]
`timescale 1ns / 1ps

package sca_pkg;

   localparam int ANGLE_W = 32;
   localparam int OUT_W = 18;
   localparam int ANGLE_FRAC_BITS = 24;
   localparam int OUT_FRAC_BITS = 16;

   // reduction in Q.40, polynomial in Q.30
   localparam int RED_FRAC = 40;
   localparam int POLY_FRAC = 30;
   localparam int RED_W = 45;
   localparam int Y30_W = 31;
   localparam int Y2_W = 32;
   localparam int ACC_W = 33;

   localparam int N_LANES = 2;
   localparam int N_TERMS = 6;
   localparam int LANE_SIN = 0;
   localparam int LANE_COS = 1;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [RED_W-1:0] PI_R = RED_W'((PI_Q60 + (64'd1 << 19)) >> 20);
   localparam logic [RED_W-1:0] HALF_PI_R = RED_W'((PI_Q60 + (64'd1 << 20)) >> 21);
   localparam logic [RED_W-1:0] TWO_PI_R = RED_W'((PI_Q60 + (64'd1 << 18)) >> 19);

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [OUT_W-1:0] out_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [RED_W-1:0] red_type;

   typedef struct packed {
      logic [Y30_W-1:0] y30_mag;
      logic y_neg;
      logic folded;
      logic [Y2_W-1:0] y2;
   } side_type;

   // horner coefficients in Q.30, highest degree first
   localparam acc_type COEF [N_LANES][N_TERMS] = '{
      '{acc_type'(-26), acc_type'(2956), acc_type'(-213040), acc_type'(8947846),
        acc_type'(-178956974), acc_type'(1073741824)},
      '{acc_type'(-280), acc_type'(26586), acc_type'(-1491253), acc_type'(44739212),
        acc_type'(-536870912), acc_type'(1073741824)}
   };

endpackage

[sv/sca_req_if.sv]
`timescale 1ns / 1ps

interface sca_req_if;
   logic valid;
   logic ready;
   sca_pkg::angle_type angle;

   modport source (output valid, output angle, input ready);
   modport sink (input valid, input angle, output ready);
endinterface

[sv/sca_rsp_if.sv]
`timescale 1ns / 1ps

interface sca_rsp_if;
   logic valid;
   logic ready;
   sca_pkg::out_type sine_value;
   sca_pkg::out_type cosine_value;

   modport source (output valid, output sine_value, output cosine_value, input ready);
   modport sink (input valid, input sine_value, input cosine_value, output ready);
endinterface

[sv/sine_cosine_approx.sv]
// sine_cosine_approx: sine and cosine of a signed fixed-point angle
//
// req_ch carries one angle per item (radians, ANGLE_FRAC_BITS fraction bits).
// rsp_ch returns one item per angle: sine_value and cosine_value in Q1.16,
// saturated to +-1.0, in the order the angles were accepted.
// Both channels move an item when valid and ready are high at a clock edge.
//
// Throughput is one item per cycle while the skid register is empty. Eleven
// stages reduce the angle (reciprocal estimate, two partial products of the
// turn count, remainder correction, fold, square), each of the five horner
// steps takes a multiply stage and a round/add stage for both polynomials in
// parallel, then two stages finish the sine product and one rounds and clamps.
//
// A synchronous reset clears the valid bits and the skid valid flag only.
// When rsp_ch.ready is low, the finished item moves into a skid register and
// req_ch.ready drops on the next cycle; the whole pipeline then holds until
// the skid item is taken. req_ch.ready depends only on registered state.
`timescale 1ns / 1ps

module sine_cosine_approx #(
   parameter int unsigned ANGLE_FRAC_BITS = sca_pkg::ANGLE_FRAC_BITS
) (
   input logic clock,
   input logic reset,
   sca_req_if.sink req_ch,
   sca_rsp_if.source rsp_ch
);

   localparam int ANGLE_W = sca_pkg::ANGLE_W;
   localparam int OUT_W = sca_pkg::OUT_W;
   localparam int RED_W = sca_pkg::RED_W;
   localparam int Y30_W = sca_pkg::Y30_W;
   localparam int Y2_W = sca_pkg::Y2_W;
   localparam int ACC_W = sca_pkg::ACC_W;
   localparam int POLY_FRAC = sca_pkg::POLY_FRAC;
   localparam int N_LANES = sca_pkg::N_LANES;
   localparam int N_STEPS = sca_pkg::N_TERMS - 1;
   localparam int NST = 24;

   localparam int SHIFT = sca_pkg::RED_FRAC - int'(ANGLE_FRAC_BITS);
   localparam int RECIP_SH = 32;
   localparam int RCP_W = SHIFT - 9;
   localparam int QW = SHIFT - 10;
   localparam int PW = ANGLE_W + RCP_W;
   localparam int T_SPLIT = 22;
   localparam int PLO_W = QW + T_SPLIT;
   localparam int PHI_W = RED_W - T_SPLIT;
   localparam int SQ_W = 2 * Y30_W;
   localparam int HP_W = ACC_W + Y2_W;
   localparam int FP_W = ACC_W + Y30_W;
   localparam int OUT_SH = POLY_FRAC - sca_pkg::OUT_FRAC_BITS;

   localparam logic [63:0] RECIP_FULL = ((64'd1 << (RECIP_SH + SHIFT))
      + 64'(sca_pkg::TWO_PI_R / 2)) / 64'(sca_pkg::TWO_PI_R);
   localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_FULL);
   localparam logic [PW:0] Q_RND = (PW+1)'(64'd1 << (RECIP_SH - 1));
   localparam logic [T_SPLIT-1:0] T_LO = T_SPLIT'(sca_pkg::TWO_PI_R);
   localparam logic [PHI_W-1:0] T_HI = PHI_W'(sca_pkg::TWO_PI_R >> T_SPLIT);

   localparam sca_pkg::red_type PI_S = sca_pkg::red_type'(sca_pkg::PI_R);
   localparam sca_pkg::red_type HALF_PI_S = sca_pkg::red_type'(sca_pkg::HALF_PI_R);
   localparam sca_pkg::red_type TWO_PI_S = sca_pkg::red_type'(sca_pkg::TWO_PI_R);
   localparam logic signed [RED_W:0] TWO_PI_D = (RED_W+1)'(sca_pkg::TWO_PI_R);
   localparam logic [RED_W-1:0] Y_RND =
      RED_W'(64'd1 << (sca_pkg::RED_FRAC - POLY_FRAC - 1));

   localparam logic [SQ_W-1:0] SQ_RND = SQ_W'(64'd1 << (POLY_FRAC - 1));
   localparam logic [HP_W-1:0] HP_RND = HP_W'(64'd1 << (POLY_FRAC - 1));
   localparam logic [FP_W-1:0] FP_RND = FP_W'(64'd1 << (POLY_FRAC - 1));
   localparam logic [ACC_W-1:0] OUT_HALF = ACC_W'((64'd1 << OUT_SH) >> 1);
   localparam logic [ACC_W-1:0] OUT_ONE = ACC_W'(64'd1 << sca_pkg::OUT_FRAC_BITS);
   localparam logic signed [OUT_W:0] OUT_ONE_S =
      (OUT_W+1)'(64'd1 << sca_pkg::OUT_FRAC_BITS);

   function automatic logic [ACC_W-1:0] mag_acc(input sca_pkg::acc_type v);
      return v[ACC_W-1] ? ACC_W'($unsigned(-v)) : ACC_W'($unsigned(v));
   endfunction

   function automatic sca_pkg::out_type to_out(input sca_pkg::acc_type v);
      logic [ACC_W-1:0] m;
      logic [ACC_W-1:0] r;
      m = mag_acc(v);
      r = (m + OUT_HALF) >> OUT_SH;
      if (r > OUT_ONE) begin
         r = OUT_ONE;
      end
      return v[ACC_W-1] ? sca_pkg::out_type'(OUT_W'(~r + 1'b1))
                        : sca_pkg::out_type'(OUT_W'(r));
   endfunction

   // handshake and valid bits
   logic en;
   logic [NST:1] vld_ff, vld_in;
   logic skid_vld_ff, skid_vld_in, skid_load;
   sca_pkg::out_type skid_sin_ff, skid_cos_ff;

   // reduction stages
   logic s1_neg_ff, s1_neg_in;
   logic [ANGLE_W-1:0] s1_mag_ff, s1_mag_in;
   logic s2_neg_ff;
   logic [ANGLE_W-1:0] s2_mag_ff;
   logic [PW-1:0] s2_prod_ff, s2_prod_in;
   logic s3_neg_ff;
   logic [ANGLE_W-1:0] s3_mag_ff;
   logic [PW:0] s3_qsum;
   logic [QW-1:0] s3_q_ff, s3_q_in;
   logic s4_neg_ff;
   logic [ANGLE_W-1:0] s4_mag_ff;
   logic [QW-1:0] s4_q_ff;
   logic [PLO_W-1:0] s4_plo_ff, s4_plo_in;
   logic s5_neg_ff;
   logic [ANGLE_W-1:0] s5_mag_ff;
   logic [PLO_W-1:0] s5_plo_ff;
   logic [PHI_W-1:0] s5_phi_ff, s5_phi_in;
   logic [RED_W-1:0] s6_a;
   logic s6_neg_ff;
   sca_pkg::red_type s6_y_ff, s6_y_in;
   logic signed [RED_W:0] s7_dbl;
   sca_pkg::red_type s7_c;
   sca_pkg::red_type s7_y_ff, s7_y_in;
   sca_pkg::red_type s8_y_ff, s8_y_in;
   logic s8_fold_ff, s8_fold_in;
   logic [RED_W-1:0] s9_abs;
   logic [Y30_W-1:0] s9_ymag_ff, s9_ymag_in;
   logic s9_yneg_ff, s9_fold_ff;
   logic [Y30_W-1:0] s10_ymag_ff;
   logic s10_yneg_ff, s10_fold_ff;
   logic [SQ_W-1:0] s10_sq_ff, s10_sq_in;
   sca_pkg::side_type s11_side_ff, s11_side_in;

   // horner steps, both polynomials side by side
   sca_pkg::acc_type acc_src [1:N_STEPS][N_LANES];
   sca_pkg::side_type side_src [1:N_STEPS];
   logic [HP_W-1:0] hm_pm_ff [1:N_STEPS][N_LANES];
   logic [HP_W-1:0] hm_pm_in [1:N_STEPS][N_LANES];
   logic hm_neg_ff [1:N_STEPS][N_LANES];
   logic hm_neg_in [1:N_STEPS][N_LANES];
   sca_pkg::side_type hm_side_ff [1:N_STEPS];
   sca_pkg::acc_type hr [1:N_STEPS][N_LANES];
   sca_pkg::acc_type ha_acc_ff [1:N_STEPS][N_LANES];
   sca_pkg::acc_type ha_acc_in [1:N_STEPS][N_LANES];
   sca_pkg::side_type ha_side_ff [1:N_STEPS];

   // sine times y, cosine sign, output rounding
   logic [FP_W-1:0] f_pm_ff, f_pm_in;
   logic f_neg_ff, f_neg_in;
   logic f_fold_ff;
   sca_pkg::acc_type f_cos_ff;
   sca_pkg::acc_type g_r;
   sca_pkg::acc_type g_sin_ff, g_sin_in, g_cos_ff, g_cos_in;
   sca_pkg::out_type o_sin_ff, o_sin_in, o_cos_ff, o_cos_in;

   assign en = !skid_vld_ff;
   assign req_ch.ready = en;

   always_comb begin
      vld_in = {vld_ff[NST-1:1], req_ch.valid};
      skid_load = !skid_vld_ff && vld_ff[NST] && !rsp_ch.ready;
      if (skid_vld_ff) begin
         skid_vld_in = !rsp_ch.ready;
      end else begin
         skid_vld_in = skid_load;
      end
   end

   // angle reduction
   always_comb begin
      s1_neg_in = req_ch.angle[ANGLE_W-1];
      s1_mag_in = s1_neg_in ? ANGLE_W'($unsigned(-req_ch.angle))
                            : ANGLE_W'($unsigned(req_ch.angle));

      // turn count estimate, off by at most one
      s2_prod_in = PW'(s1_mag_ff) * PW'(RECIP);
      s3_qsum = {1'b0, s2_prod_ff} + Q_RND;
      s3_q_in = s3_qsum[RECIP_SH +: QW];

      // count times 2*pi, modulo the remainder width
      s4_plo_in = PLO_W'(s3_q_ff) * PLO_W'(T_LO);
      s5_phi_in = PHI_W'(s4_q_ff) * T_HI;
      s6_a = RED_W'({s5_mag_ff, {SHIFT{1'b0}}});
      s6_y_in = sca_pkg::red_type'(s6_a - RED_W'(s5_plo_ff)
                                   - {s5_phi_ff, {T_SPLIT{1'b0}}});

      // correct the estimate so that -pi <= y < pi, halves away from zero
      s7_dbl = {s6_y_ff, 1'b0};
      priority if (s7_dbl < -TWO_PI_D) begin
         s7_c = s6_y_ff + TWO_PI_S;
      end else if (s7_dbl >= TWO_PI_D) begin
         s7_c = s6_y_ff - TWO_PI_S;
      end else begin
         s7_c = s6_y_ff;
      end
      s7_y_in = s6_neg_ff ? -s7_c : s7_c;

      // fold into [-pi/2, pi/2]
      priority if (s7_y_ff > HALF_PI_S) begin
         s8_y_in = PI_S - s7_y_ff;
         s8_fold_in = 1'b1;
      end else if (s7_y_ff < -HALF_PI_S) begin
         s8_y_in = -PI_S - s7_y_ff;
         s8_fold_in = 1'b1;
      end else begin
         s8_y_in = s7_y_ff;
         s8_fold_in = 1'b0;
      end

      s9_abs = s8_y_ff[RED_W-1] ? RED_W'($unsigned(-s8_y_ff)) : RED_W'($unsigned(s8_y_ff));
      s9_ymag_in = Y30_W'((s9_abs + Y_RND) >> (sca_pkg::RED_FRAC - POLY_FRAC));

      s10_sq_in = SQ_W'(s9_ymag_ff) * SQ_W'(s9_ymag_ff);

      s11_side_in.y30_mag = s10_ymag_ff;
      s11_side_in.y_neg = s10_yneg_ff;
      s11_side_in.folded = s10_fold_ff;
      s11_side_in.y2 = Y2_W'((s10_sq_ff + SQ_RND) >> POLY_FRAC);
   end

   // horner: multiply stage, then round and add coefficient
   always_comb begin
      side_src[1] = s11_side_ff;
      for (int l = 0; l < N_LANES; l++) begin
         acc_src[1][l] = sca_pkg::COEF[l][0];
      end
      for (int k = 2; k <= N_STEPS; k++) begin
         side_src[k] = ha_side_ff[k-1];
         for (int l = 0; l < N_LANES; l++) begin
            acc_src[k][l] = ha_acc_ff[k-1][l];
         end
      end
      for (int k = 1; k <= N_STEPS; k++) begin
         for (int l = 0; l < N_LANES; l++) begin
            hm_pm_in[k][l] = HP_W'(mag_acc(acc_src[k][l])) * HP_W'(side_src[k].y2);
            hm_neg_in[k][l] = acc_src[k][l][ACC_W-1];
            hr[k][l] = sca_pkg::acc_type'(ACC_W'((hm_pm_ff[k][l] + HP_RND) >> POLY_FRAC));
            ha_acc_in[k][l] = (hm_neg_ff[k][l] ? -hr[k][l] : hr[k][l])
                              + sca_pkg::COEF[l][k];
         end
      end
   end

   always_comb begin
      f_pm_in = FP_W'(mag_acc(ha_acc_ff[N_STEPS][sca_pkg::LANE_SIN]))
                * FP_W'(ha_side_ff[N_STEPS].y30_mag);
      f_neg_in = ha_acc_ff[N_STEPS][sca_pkg::LANE_SIN][ACC_W-1] ^ ha_side_ff[N_STEPS].y_neg;
      g_r = sca_pkg::acc_type'(ACC_W'((f_pm_ff + FP_RND) >> POLY_FRAC));
      g_sin_in = f_neg_ff ? -g_r : g_r;
      g_cos_in = f_fold_ff ? -f_cos_ff : f_cos_ff;
      o_sin_in = to_out(g_sin_ff);
      o_cos_in = to_out(g_cos_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= vld_in;
         end
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_load) begin
         skid_sin_ff <= o_sin_ff;
         skid_cos_ff <= o_cos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_neg_ff <= s1_neg_in;
         s1_mag_ff <= s1_mag_in;
         s2_neg_ff <= s1_neg_ff;
         s2_mag_ff <= s1_mag_ff;
         s2_prod_ff <= s2_prod_in;
         s3_neg_ff <= s2_neg_ff;
         s3_mag_ff <= s2_mag_ff;
         s3_q_ff <= s3_q_in;
         s4_neg_ff <= s3_neg_ff;
         s4_mag_ff <= s3_mag_ff;
         s4_q_ff <= s3_q_ff;
         s4_plo_ff <= s4_plo_in;
         s5_neg_ff <= s4_neg_ff;
         s5_mag_ff <= s4_mag_ff;
         s5_plo_ff <= s4_plo_ff;
         s5_phi_ff <= s5_phi_in;
         s6_neg_ff <= s5_neg_ff;
         s6_y_ff <= s6_y_in;
         s7_y_ff <= s7_y_in;
         s8_y_ff <= s8_y_in;
         s8_fold_ff <= s8_fold_in;
         s9_ymag_ff <= s9_ymag_in;
         s9_yneg_ff <= s8_y_ff[RED_W-1];
         s9_fold_ff <= s8_fold_ff;
         s10_ymag_ff <= s9_ymag_ff;
         s10_yneg_ff <= s9_yneg_ff;
         s10_fold_ff <= s9_fold_ff;
         s10_sq_ff <= s10_sq_in;
         s11_side_ff <= s11_side_in;
         for (int k = 1; k <= N_STEPS; k++) begin
            hm_side_ff[k] <= side_src[k];
            ha_side_ff[k] <= hm_side_ff[k];
            for (int l = 0; l < N_LANES; l++) begin
               hm_pm_ff[k][l] <= hm_pm_in[k][l];
               hm_neg_ff[k][l] <= hm_neg_in[k][l];
               ha_acc_ff[k][l] <= ha_acc_in[k][l];
            end
         end
         f_pm_ff <= f_pm_in;
         f_neg_ff <= f_neg_in;
         f_fold_ff <= ha_side_ff[N_STEPS].folded;
         f_cos_ff <= ha_acc_ff[N_STEPS][sca_pkg::LANE_COS];
         g_sin_ff <= g_sin_in;
         g_cos_ff <= g_cos_in;
         o_sin_ff <= o_sin_in;
         o_cos_ff <= o_cos_in;
      end
   end

   assign rsp_ch.valid = skid_vld_ff || vld_ff[NST];
   assign rsp_ch.sine_value = skid_vld_ff ? skid_sin_ff : o_sin_ff;
   assign rsp_ch.cosine_value = skid_vld_ff ? skid_cos_ff : o_cos_ff;

`ifndef NO_ASSERTIONS
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(vld_ff[NST] && !rsp_ch.ready))
      else $error("skid register filled without a stalled item");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(vld_ff))
      else $error("pipeline moved while skid register was full");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && sca_pkg::OUT_FRAC_BITS <= OUT_W - 2) |->
         (rsp_ch.sine_value <= OUT_ONE_S && rsp_ch.sine_value >= -OUT_ONE_S &&
          rsp_ch.cosine_value <= OUT_ONE_S && rsp_ch.cosine_value >= -OUT_ONE_S))
      else $error("result beyond plus or minus one");
`endif

endmodule

[bench/sca_sin_cos_checker.sv]
`timescale 1ns / 1ps

module sca_sin_cos_checker (
   input logic clock,
   input logic reset,
   sca_req_if req_mon,
   sca_rsp_if rsp_mon,
   output int mismatches,
   output int outstanding
);

   typedef struct {
      sca_pkg::out_type sine;
      sca_pkg::out_type cosine;
   } sin_cos_pair_type;

   localparam bit [63:0] PI_Q60_CONST = 64'h3243F6A8885A308D;
   localparam longint PI_Q40 = longint'((PI_Q60_CONST + (64'd1 << 19)) >> 20);
   localparam longint HALF_PI_Q40 = longint'((PI_Q60_CONST + (64'd1 << 20)) >> 21);
   localparam longint TWO_PI_Q40 = longint'((PI_Q60_CONST + (64'd1 << 18)) >> 19);

   localparam longint SIN_TAPS [0:5] = '{
      -26, 2956, -213040, 8947846, -178956974, 1073741824
   };
   localparam longint COS_TAPS [0:5] = '{
      -280, 26586, -1491253, 44739212, -536870912, 1073741824
   };

   sin_cos_pair_type sincos_due [$];

   function automatic bit [63:0] magn(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint round_half_away(input longint v, input int sh);
      bit [63:0] m;
      m = (magn(v) + ((64'd1 << sh) >> 1)) >> sh;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint qmul30(input longint a, input longint b);
      bit [63:0] m;
      m = (magn(a) * magn(b) + (64'd1 << (sca_pkg::POLY_FRAC - 1))) >> sca_pkg::POLY_FRAC;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint horner_eval(input bit use_cos, input longint y2);
      longint acc;
      acc = use_cos ? COS_TAPS[0] : SIN_TAPS[0];
      for (int i = 1; i < 6; i++) begin
         acc = qmul30(acc, y2) + (use_cos ? COS_TAPS[i] : SIN_TAPS[i]);
      end
      return acc;
   endfunction

   function automatic sca_pkg::out_type to_out_fmt(input longint v);
      longint one;
      longint r;
      one = longint'(1) << sca_pkg::OUT_FRAC_BITS;
      r = round_half_away(v, sca_pkg::POLY_FRAC - sca_pkg::OUT_FRAC_BITS);
      if (r > one) begin
         r = one;
      end
      if (r < -one) begin
         r = -one;
      end
      return sca_pkg::out_type'(r);
   endfunction

   function automatic sin_cos_pair_type predict_sin_cos(input sca_pkg::angle_type ang);
      bit [31:0] raw;
      bit neg;
      bit [63:0] mag;
      bit [63:0] a;
      bit [63:0] q;
      longint y;
      longint y30;
      longint y2;
      longint c;
      bit folded;
      sin_cos_pair_type res;
      raw = ang;
      neg = raw[31];
      mag = neg ? (64'h1_0000_0000 - 64'(raw)) : 64'(raw);
      a = mag << (sca_pkg::RED_FRAC - sca_pkg::ANGLE_FRAC_BITS);
      q = (2 * a + 64'(TWO_PI_Q40)) / (2 * 64'(TWO_PI_Q40));
      y = longint'(a) - longint'(q * 64'(TWO_PI_Q40));
      folded = 1'b0;
      if (neg) begin
         y = -y;
      end
      if (y > HALF_PI_Q40) begin
         y = PI_Q40 - y;
         folded = 1'b1;
      end else if (y < -HALF_PI_Q40) begin
         y = -PI_Q40 - y;
         folded = 1'b1;
      end
      y30 = round_half_away(y, sca_pkg::RED_FRAC - sca_pkg::POLY_FRAC);
      y2 = qmul30(y30, y30);
      c = horner_eval(1'b1, y2);
      if (folded) begin
         c = -c;
      end
      res.sine = to_out_fmt(qmul30(horner_eval(1'b0, y2), y30));
      res.cosine = to_out_fmt(c);
      return res;
   endfunction

   always @(posedge clock) begin
      sin_cos_pair_type want;
      if (reset) begin
         mismatches <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (sincos_due.size() == 0) begin
               $display("%0t: unexpected item sine %0d cosine %0d", $time,
                        rsp_mon.sine_value, rsp_mon.cosine_value);
               mismatches <= mismatches + 1;
            end else begin
               want = sincos_due.pop_front();
               if (rsp_mon.sine_value !== want.sine ||
                   rsp_mon.cosine_value !== want.cosine) begin
                  $display("%0t: sine expected %0d actual %0d, cosine expected %0d actual %0d",
                           $time, want.sine, rsp_mon.sine_value,
                           want.cosine, rsp_mon.cosine_value);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            sincos_due.push_back(predict_sin_cos(req_mon.angle));
         end
         outstanding <= sincos_due.size();
      end
   end

endmodule

[bench/tb_sine_cosine_approx.sv]
`timescale 1ns / 1ps

module tb_sine_cosine_approx;

   localparam int NUM_RANDOM = 1750;
   localparam int HOLD_START = 900;
   localparam int HOLD_LEN = 120;

   logic clock;
   logic reset;
   bit gaps_on;
   int mismatches;
   int outstanding;

   sca_req_if req_ch ();
   sca_rsp_if rsp_ch ();

   sine_cosine_approx uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   sca_sin_cos_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_mon(req_ch),
      .rsp_mon(rsp_ch),
      .mismatches(mismatches),
      .outstanding(outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic sca_pkg::angle_type near_q40(input longint q40, input int offset);
      return sca_pkg::angle_type'((q40 >>> (sca_pkg::RED_FRAC - sca_pkg::ANGLE_FRAC_BITS))
                                  + offset);
   endfunction

   function automatic sca_pkg::angle_type pick_angle();
      int kind;
      int k;
      kind = $urandom_range(99);
      k = $urandom_range(160);
      if (kind < 30) begin
         return sca_pkg::angle_type'($urandom);
      end else if (kind < 60) begin
         return sca_pkg::angle_type'(int'($urandom_range(268435455)) - 134217728);
      end else if (kind < 85) begin
         return near_q40(longint'(k - 80) * longint'(sca_pkg::HALF_PI_R),
                         int'($urandom_range(64)) - 32);
      end else if ($urandom_range(1) == 1) begin
         return sca_pkg::angle_type'({16'h7FFF, 16'($urandom)});
      end else begin
         return sca_pkg::angle_type'({16'h8000, 16'($urandom)});
      end
   endfunction

   task automatic send_angle(input sca_pkg::angle_type value);
      while (gaps_on && $urandom_range(99) < 24) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.angle <= value;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // receiver: random stalls, one long hold-off, calm while the sender is calm
   initial begin
      int unsigned cyc;
      cyc = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
            rsp_ch.ready <= 1'b0;
         end else if (!gaps_on) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 24);
         end
      end
   end

   initial begin
      longint half_pi;
      longint pi_q;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.angle = '0;
      gaps_on = 1'b1;
      half_pi = longint'(sca_pkg::HALF_PI_R);
      pi_q = longint'(sca_pkg::PI_R);
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes of the angle field
      send_angle(sca_pkg::angle_type'(0));
      send_angle(sca_pkg::angle_type'(1));
      send_angle(sca_pkg::angle_type'(-1));
      send_angle(sca_pkg::angle_type'(32'h7FFFFFFF));
      send_angle(sca_pkg::angle_type'(32'h80000000));
      send_angle(sca_pkg::angle_type'(32'h80000001));
      // fold boundary
      for (int d = -1; d <= 1; d++) begin
         send_angle(near_q40(half_pi, d));
         send_angle(near_q40(-half_pi, d));
      end
      // half turns
      for (int d = -1; d <= 1; d++) begin
         send_angle(near_q40(pi_q, d));
         send_angle(near_q40(-pi_q, d));
      end
      send_angle(near_q40(39 * pi_q, -1));
      send_angle(near_q40(39 * pi_q, 1));
      send_angle(near_q40(-39 * pi_q, 0));
      send_angle(near_q40(2 * pi_q, 0));

      for (int i = 0; i < NUM_RANDOM; i++) begin
         gaps_on = !(i >= 1000 && i < 1300);
         send_angle(pick_angle());
      end
      req_ch.valid <= 1'b0;

      wait (outstanding == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule
